/* src/periodic_timer_queue_unit_defines.svh */
// Assertion macros shared by the timer queue RTL.
`ifndef PERIODIC_TIMER_QUEUE_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_QUEUE_UNIT_DEFINES_SVH

// Same-cycle check: when ante holds, cons must hold too.
`define PTQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle check: when ante holds, cons must hold in the next cycle.
`define PTQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/ptq_pkg.sv */
// Package for the periodic timer queue: sizes, codes and transaction types.
`timescale 1ns / 1ps

package ptq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_CNT_W = 5;

	// Commands on the input channel
	localparam logic [1:0] CMD_INSERT   = 2'd0;
	localparam logic [1:0] CMD_REINSERT = 2'd1;
	localparam logic [1:0] CMD_TICK     = 2'd2;
	localparam logic [1:0] CMD_CLEAR    = 2'd3;

	// Result status codes
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_FULL      = 2'd1;
	localparam logic [1:0] STS_EMPTY_RIN = 2'd2;

	// Operations broadcast to the cell chain
	localparam logic [2:0] OP_HOLD     = 3'd0;
	localparam logic [2:0] OP_INSERT   = 3'd1;
	localparam logic [2:0] OP_REINSERT = 3'd2;
	localparam logic [2:0] OP_TICK     = 3'd3;
	localparam logic [2:0] OP_CLEAR    = 3'd4;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] entry_id;
		logic [31:0] period;
		logic [31:0] elapsed;
	} in_item_t;

	typedef struct packed {
		logic                   queue_empty;
		logic [15:0]            head_id;
		logic [31:0]            head_remaining;
		logic [31:0]            head_period;
		logic [ENTRY_CNT_W-1:0] entry_count;
		logic [1:0]             status;
	} out_item_t;

	// Contents of one queue slot
	typedef struct packed {
		logic [15:0] id;
		logic [31:0] remaining;
		logic [31:0] period;
	} slot_t;

	// Control broadcast from the top level to every cell
	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] key;
		slot_t       new_slot;
		logic [31:0] elapsed;
	} cell_ctrl_t;

endpackage

/* src/ptq_cell.sv */
// One slot of the sorted timer queue; exchanges entries with its two neighbors.
`timescale 1ns / 1ps

module ptq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  ptq_pkg::cell_ctrl_t ctrl,
	input  logic               head_cell,
	input  ptq_pkg::slot_t     left_slot,
	input  logic               left_valid,
	input  logic               left_lt,
	input  ptq_pkg::slot_t     right_slot,
	input  logic               right_lt,
	output ptq_pkg::slot_t     slot,
	output logic               valid,
	output logic               lt
);

	ptq_pkg::slot_t slot_q;
	ptq_pkg::slot_t slot_d;
	logic           valid_q;
	logic           valid_d;
	logic [32:0]    tick_diff;

	// Entry sorts ahead of the broadcast key
	assign lt        = valid_q && (slot_q.remaining < ctrl.key);
	assign tick_diff = {1'b0, slot_q.remaining} - {1'b0, ctrl.elapsed};

	// Next slot contents
	always_comb begin
		slot_d  = slot_q;
		valid_d = valid_q;
		unique case (ctrl.op)
			ptq_pkg::OP_INSERT: begin
				// earlier entries stay, the first cell without an earlier entry takes the new job, the rest move back
				if (lt) begin
					slot_d = slot_q;
				end else if (head_cell || left_lt) begin
					slot_d = ctrl.new_slot;
				end else begin
					slot_d = left_slot;
				end
				valid_d = valid_q | left_valid | head_cell;
			end
			ptq_pkg::OP_REINSERT: begin
				// head leaves: earlier entries move forward, the old head lands after them
				if (right_lt) begin
					slot_d = right_slot;
				end else if (head_cell || lt) begin
					slot_d = ctrl.new_slot;
				end else begin
					slot_d = slot_q;
				end
			end
			ptq_pkg::OP_TICK: begin
				slot_d.remaining = tick_diff[32] ? 32'd0 : tick_diff[31:0];
			end
			ptq_pkg::OP_CLEAR: begin
				valid_d = 1'b0;
			end
			default: begin
				slot_d  = slot_q;
				valid_d = valid_q;
			end
		endcase
	end

	// Slot payload, no reset
	always_ff @(posedge clk) begin
		slot_q <= slot_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	assign slot  = slot_q;
	assign valid = valid_q;

endmodule

/* src/periodic_timer_queue_unit.sv */
// Periodic timer queue top level: command decode, cell chain and result channel.
`timescale 1ns / 1ps
`include "periodic_timer_queue_unit_defines.svh"

// Sorted queue of up to ptq_pkg::QUEUE_DEPTH periodic jobs held in a chain of
// cells, slot 0 being the head. Every command (insert, reinsert head, tick,
// clear) acts on all cells at once: they compare against one broadcast key
// and shift, take or subtract in the same clock, so a new command is accepted
// in every cycle while the result side keeps taking. Each command gives one
// result transaction, valid the cycle after acceptance, reporting the head
// job, the fill level and a status. The result is held in the cells and the
// output flops; in_stall rises only while a result waits under out_stall.

module periodic_timer_queue_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ptq_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output ptq_pkg::out_item_t out_item
);

	localparam int D = ptq_pkg::QUEUE_DEPTH;

	ptq_pkg::cell_ctrl_t            ctrl;
	ptq_pkg::slot_t                 slot_arr [D];
	logic [D-1:0]                   valid_vec;
	logic [D-1:0]                   lt_vec;
	logic [ptq_pkg::CNT_W-1:0]      count_q;
	logic [ptq_pkg::CNT_W-1:0]      count_d;
	logic [1:0]                     status_q;
	logic [1:0]                     status_d;
	logic                           out_valid_q;
	logic                           accept;
	logic                           full;
	logic                           empty;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = valid_vec[D-1];
	assign empty    = !valid_vec[0];

	// Command decode into the broadcast control
	always_comb begin
		ctrl.op       = ptq_pkg::OP_HOLD;
		ctrl.key      = in_item.period;
		ctrl.new_slot = '{id: in_item.entry_id, remaining: in_item.period,
			period: in_item.period};
		ctrl.elapsed  = in_item.elapsed;
		status_d      = ptq_pkg::STS_OK;
		count_d       = count_q;
		unique case (in_item.command)
			ptq_pkg::CMD_INSERT: begin
				if (full) begin
					status_d = ptq_pkg::STS_FULL;
				end else begin
					ctrl.op = ptq_pkg::OP_INSERT;
					count_d = count_q + 1'b1;
				end
			end
			ptq_pkg::CMD_REINSERT: begin
				ctrl.key      = slot_arr[0].period;
				ctrl.new_slot = '{id: slot_arr[0].id, remaining: slot_arr[0].period,
					period: slot_arr[0].period};
				if (empty) begin
					status_d = ptq_pkg::STS_EMPTY_RIN;
				end else begin
					ctrl.op = ptq_pkg::OP_REINSERT;
				end
			end
			ptq_pkg::CMD_TICK: begin
				ctrl.op = ptq_pkg::OP_TICK;
			end
			ptq_pkg::CMD_CLEAR: begin
				ctrl.op = ptq_pkg::OP_CLEAR;
				count_d = '0;
			end
			default: begin
				ctrl.op = ptq_pkg::OP_HOLD;
			end
		endcase
		if (!accept) begin
			ctrl.op = ptq_pkg::OP_HOLD;
		end
	end

	// Cell chain
	for (genvar k = 0; k < D; k++) begin : g_cell
		ptq_pkg::slot_t left_slot;
		ptq_pkg::slot_t right_slot;
		logic           left_valid;
		logic           left_lt;
		logic           right_lt;

		if (k == 0) begin : g_first
			assign left_slot  = '0;
			assign left_valid = 1'b0;
			assign left_lt    = 1'b0;
		end else begin : g_inner
			assign left_slot  = slot_arr[k-1];
			assign left_valid = valid_vec[k-1];
			assign left_lt    = lt_vec[k-1];
		end

		if (k == D - 1) begin : g_last
			assign right_slot = '0;
			assign right_lt   = 1'b0;
		end else begin : g_body
			assign right_slot = slot_arr[k+1];
			assign right_lt   = lt_vec[k+1];
		end

		ptq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.head_cell  (k == 0),
			.left_slot  (left_slot),
			.left_valid (left_valid),
			.left_lt    (left_lt),
			.right_slot (right_slot),
			.right_lt   (right_lt),
			.slot       (slot_arr[k]),
			.valid      (valid_vec[k]),
			.lt         (lt_vec[k])
		);
	end

	// Fill count and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

	// Result transaction built from the head cell, the fill count and the status
	assign out_valid                = out_valid_q;
	assign out_item.queue_empty     = empty;
	assign out_item.head_id         = empty ? 16'd0 : slot_arr[0].id;
	assign out_item.head_remaining  = empty ? 32'd0 : slot_arr[0].remaining;
	assign out_item.head_period     = empty ? 32'd0 : slot_arr[0].period;
	assign out_item.entry_count     = ptq_pkg::ENTRY_CNT_W'(count_q);
	assign out_item.status          = status_q;

	// Checks
	`PTQ_ASSERT_NOW(a_count_matches, 1'b1, count_q == ptq_pkg::CNT_W'($countones(valid_vec)),
		"fill count differs from held cells")
	`PTQ_ASSERT_NOW(a_valid_prefix, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0,
		"held cells do not form a prefix")
	`PTQ_ASSERT_NEXT(a_clear_empties, accept && (in_item.command == ptq_pkg::CMD_CLEAR),
		valid_vec == '0, "clear left cells held")
	`PTQ_ASSERT_NEXT(a_full_drop, accept && full && (in_item.command == ptq_pkg::CMD_INSERT),
		$stable(valid_vec) && (status_q == ptq_pkg::STS_FULL), "insert on full not dropped")
	`PTQ_ASSERT_NEXT(a_result_follows, accept, out_valid, "no result after accepted command")

endmodule
